[design/efr_pkg.sv]
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Byte codes of the escape scheme, counter limits, status codes and the
// result record that travels from the decoder to the result queue.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int MAX_FRAME_BYTES = 1024;
  localparam int COUNT_W         = 11;
  // Counters stop at the frame size, or at what 11 bits can hold.
  localparam int COUNT_CAP       = (MAX_FRAME_BYTES < 2047) ? MAX_FRAME_BYTES : 2047;
  localparam logic [COUNT_W-1:0] COUNT_CAP_V = COUNT_W'(COUNT_CAP);

  localparam logic [COUNT_W-1:0] MIN_LEN_RESET = COUNT_W'(9);

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;

  // Byte positions of the decoded header.
  localparam logic [COUNT_W-1:0] IDX_CHECKSUM = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] IDX_FLOW_HI  = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] IDX_FLOW_LO  = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] IDX_SUM_FROM = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] IDX_FUNCTION = COUNT_W'(6);

  localparam logic [1:0] FLAG_COUNT_MAX  = 2'd3;
  localparam logic [1:0] FLAG_COUNT_GOOD = 2'd2;

  // Result queue: power-of-two depth, room for the two results of one item.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FLAG_COUNT = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_BAD_ESCAPE = 3'd3,
    ST_CHECKSUM   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         out_byte;
    status_t            status;
    logic [15:0]        flow_id;
    logic [7:0]         function_code;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

  // Results produced by one item: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[design/efr_frame_decoder.sv]
// ----------------------------------------------------------------------------
// efr_frame_decoder: per-frame unescape state and result forming
// Decodes one raw byte per step, keeps the frame's counters, sum and header
// captures, and forms the data result and the end-of-frame status result.
// ----------------------------------------------------------------------------
module efr_frame_decoder
  import efr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  input  logic [COUNT_W-1:0] min_raw_length,
  output push_t              push
);

  logic               escape_pending, escape_pending_next;
  logic [1:0]         flag_count, flag_count_next;
  logic [COUNT_W-1:0] raw_count, raw_count_next;
  logic [COUNT_W-1:0] unescaped_count, unescaped_count_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         stored_checksum, stored_checksum_next;
  logic [15:0]        captured_flow_id, captured_flow_id_next;
  logic [7:0]         captured_function, captured_function_next;
  logic               escape_error, escape_error_next;

  logic       take;
  logic [7:0] take_val;
  status_t    frame_status;
  result_t    data_res;
  result_t    stat_res;

  always_comb begin
    escape_pending_next    = escape_pending;
    flag_count_next        = flag_count;
    raw_count_next         = raw_count;
    unescaped_count_next   = unescaped_count;
    running_sum_next       = running_sum;
    stored_checksum_next   = stored_checksum;
    captured_flow_id_next  = captured_flow_id;
    captured_function_next = captured_function;
    escape_error_next      = escape_error;
    take                   = 1'b0;
    take_val               = 8'h00;

    if (raw_count < COUNT_CAP_V) begin
      raw_count_next = raw_count + COUNT_W'(1);
    end
    if (data_byte == FLAG_BYTE && flag_count != FLAG_COUNT_MAX) begin
      flag_count_next = flag_count + 2'd1;
    end

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (!escape_error && data_byte == ESC_FLAG) begin
        take     = 1'b1;
        take_val = FLAG_BYTE;
      end else if (!escape_error && data_byte == ESC_ESC) begin
        take     = 1'b1;
        take_val = ESC_BYTE;
      end else begin
        escape_error_next = 1'b1;
      end
    end else if (data_byte == ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else if (data_byte != FLAG_BYTE && !escape_error) begin
      take     = 1'b1;
      take_val = data_byte;
    end

    if (take) begin
      if (unescaped_count == IDX_CHECKSUM) begin
        stored_checksum_next = take_val;
      end else if (unescaped_count == IDX_FLOW_HI) begin
        captured_flow_id_next[15:8] = take_val;
      end else if (unescaped_count == IDX_FLOW_LO) begin
        captured_flow_id_next[7:0] = take_val;
      end else if (unescaped_count == IDX_FUNCTION) begin
        captured_function_next = take_val;
      end
      if (unescaped_count >= IDX_SUM_FROM) begin
        running_sum_next = running_sum + take_val;
      end
      if (unescaped_count < COUNT_CAP_V) begin
        unescaped_count_next = unescaped_count + COUNT_W'(1);
      end
    end

    // An escape byte that ends the frame has nothing to pair with.
    if (is_last && escape_pending_next) begin
      escape_error_next = 1'b1;
    end

    if (flag_count_next != FLAG_COUNT_GOOD) begin
      frame_status = ST_FLAG_COUNT;
    end else if (raw_count_next < min_raw_length) begin
      frame_status = ST_TOO_SHORT;
    end else if (escape_error_next) begin
      frame_status = ST_BAD_ESCAPE;
    end else if (running_sum_next != stored_checksum_next) begin
      frame_status = ST_CHECKSUM;
    end else begin
      frame_status = ST_OK;
    end

    data_res               = '0;
    data_res.kind          = KIND_DATA;
    data_res.out_byte      = take_val;
    data_res.status        = ST_OK;

    stat_res               = '0;
    stat_res.kind          = KIND_STATUS;
    stat_res.status        = frame_status;
    stat_res.flow_id       = captured_flow_id_next;
    stat_res.function_code = captured_function_next;
    stat_res.frame_length  = unescaped_count_next;

    push.first  = take ? data_res : stat_res;
    push.second = stat_res;
    push.count  = step ? ({1'b0, take} + {1'b0, is_last}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      escape_pending    <= 1'b0;
      flag_count        <= 2'd0;
      raw_count         <= '0;
      unescaped_count   <= '0;
      running_sum       <= 8'h00;
      stored_checksum   <= 8'h00;
      captured_flow_id  <= 16'h0000;
      captured_function <= 8'h00;
      escape_error      <= 1'b0;
    end else if (step) begin
      escape_pending    <= escape_pending_next;
      flag_count        <= flag_count_next;
      raw_count         <= raw_count_next;
      unescaped_count   <= unescaped_count_next;
      running_sum       <= running_sum_next;
      stored_checksum   <= stored_checksum_next;
      captured_flow_id  <= captured_flow_id_next;
      captured_function <= captured_function_next;
      escape_error      <= escape_error_next;
    end
  end

endmodule

[design/efr_result_queue.sv]
// ----------------------------------------------------------------------------
// efr_result_queue: small result queue in front of the output channel
// Takes up to two results a cycle, and gives up one a cycle from the head when popped.
// ----------------------------------------------------------------------------
module efr_result_queue
  import efr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              pop,
  output result_t           head,
  output logic [QCNT_W-1:0] count
);

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr + QPTR_W'(1);
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule

[design/escaped_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core: byte unescaper and frame checker
// Drops flag bytes, undoes the two-byte escapes, streams decoded bytes out
// and closes each frame with a status item carrying the header fields.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in       | in        | in_valid / in_stall  | in_byte, last_byte
//  out      | out       | out_valid / out_stall| kind, out_byte, status, flow_id,
//           |           |                      | function_code, frame_length
//  cfg      | in        | cfg_we               | cfg_data (min_raw_length)
//
//  One raw byte is taken per cycle while in_stall is low. It is held in the
//  input register, is decoded there and its results land in a four-entry
//  queue, from whose head the output channel offers them.
//  A byte makes zero, one or two items; the output drains one item a cycle
//  while out_stall is low, so the closing byte of a frame adds its status item.
//  The input register advances only while the queue has room for two items;
//  otherwise in_stall rises and the byte holds.
//  rst (synchronous) clears the frame state, the queue and the input
//  register, and sets the minimum raw length back to 9.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_core
  import efr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  // raw byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               last_byte,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [7:0]         out_byte,
  output logic [2:0]         status,
  output logic [15:0]        flow_id,
  output logic [7:0]         function_code,
  output logic [COUNT_W-1:0] frame_length
);

  logic [COUNT_W-1:0] min_raw_length;

  // Input register.
  logic               in_full;
  logic [7:0]         in_q_byte;
  logic               in_q_last;

  logic               in_accept;
  logic               step;
  logic               pop;
  push_t              push;
  result_t            head;
  logic [QCNT_W-1:0]  q_count;

  // Advance the held byte only when the queue can take both of its results.
  assign step      = in_full && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_stall  = in_full && !step;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = (q_count != '0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_raw_length <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      min_raw_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  // Payload of the input register: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_byte <= in_byte;
      in_q_last <= last_byte;
    end
  end

  efr_frame_decoder u_decoder (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (in_q_byte),
    .is_last        (in_q_last),
    .min_raw_length (min_raw_length),
    .push           (push)
  );

  efr_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  // Drive the output fields straight from the queue head.
  assign kind          = head.kind;
  assign out_byte      = head.out_byte;
  assign status        = head.status;
  assign flow_id       = head.flow_id;
  assign function_code = head.function_code;
  assign frame_length  = head.frame_length;

endmodule

[design/efr_checker.sv]
// ----------------------------------------------------------------------------
// efr_checker: port-level checks of the escaped frame receiver
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module efr_checker
  import efr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               kind,
  input logic [7:0]         out_byte,
  input logic [2:0]         status,
  input logic [15:0]        flow_id,
  input logic [7:0]         function_code,
  input logic [COUNT_W-1:0] frame_length
);

  // A stalled item stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The input holds off only behind a backed-up output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with nothing offered");

  // Data items carry only the byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |->
      status == ST_OK && flow_id == 16'h0000 &&
      function_code == 8'h00 && frame_length == '0)
    else $error("data item with status fields set");

  // Status items carry no byte, a known code and a bounded length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |->
      out_byte == 8'h00 && status <= ST_CHECKSUM && frame_length <= COUNT_CAP_V)
    else $error("malformed status item");

endmodule

bind escaped_frame_receiver_core efr_checker u_efr_checker (.*);
